/* rtl/ihexld_pkg.sv */
// shared types, codes and constants of the intel hex record loader
// no dependencies; used by ihexld_dp, ihexld_ctrl and the top level
package ihexld_pkg;

	// record buffer depth and fixed record layout
	localparam int RECORD_BYTES_DEF = 21;
	localparam int HDR_BYTES        = 6;
	localparam int MAX_DATA_BYTES   = 16;

	// ascii characters and nibble offsets
	localparam logic [7:0] CHAR_LF       = 8'h0A;
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
	localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

	// record types
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EOF     = 8'h01;
	localparam logic [7:0] REC_EXT_SEG = 8'h02;
	localparam logic [7:0] REC_EXT_LIN = 8'h04;

	// result kinds
	localparam logic [2:0] KIND_WRITE    = 3'd0;
	localparam logic [2:0] KIND_ERASE    = 3'd1;
	localparam logic [2:0] KIND_EOF      = 3'd2;
	localparam logic [2:0] KIND_CSUM_ERR = 3'd3;
	localparam logic [2:0] KIND_TOO_LONG = 3'd4;

	// input beat
	typedef struct packed {
		logic [7:0] ascii_char;
		logic       stream_end;
	} char_beat_t;

	// output beat
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] address;
		logic [31:0] word_data;
		logic        last;
	} result_beat_t;

	// controller to datapath commands
	typedef struct packed {
		logic       take_char;
		logic       pad;
		logic       clear;
		logic       set_upper;
		logic       start_data;
		logic       rd;
		logic       merge;
		logic       emit;
		logic [2:0] emit_kind;
		logic       emit_last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic       char_lf;
		logic       char_end;
		logic       char_overflow;
		logic       pad_overflow;
		logic       count_zero;
		logic       sum_nz;
		logic [7:0] rec_type;
		logic       len_zero;
		logic       lane_last;
		logic       last_word;
		logic       erase_done;
		logic       out_free;
	} sts_t;

endpackage

/* rtl/ihexld_dp.sv */
// datapath of the intel hex record loader: nibble decode, record buffer,
// checksum, address registers, word assembly and the output register
// depends on ihexld_pkg
module ihexld_dp #(
	parameter int RECORD_BYTES = ihexld_pkg::RECORD_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ihexld_pkg::char_beat_t   char_beat,
	input  ihexld_pkg::cmd_t         cmd,
	output ihexld_pkg::sts_t         sts,
	output logic                     result_valid,
	input  logic                     result_stall,
	output ihexld_pkg::result_beat_t result_beat
);

	localparam int CW = $clog2(RECORD_BYTES + 1);
	localparam int AW = $clog2(RECORD_BYTES);
	localparam int XW = (CW > 6) ? CW : 6;

	// record buffer memory
	logic [7:0] mem [RECORD_BYTES];
	logic [7:0] rd_q;

	// line state
	logic [7:0]    hdr_q [ihexld_pkg::HDR_BYTES];
	logic [CW-1:0] count_q;
	logic          line_started_q;
	logic          pend_q;
	logic [3:0]    hn_q;
	logic [7:0]    sum_q;
	logic [31:0]   upper_q;
	logic          erase_done_q;

	// word assembly
	logic [31:0] addr_q;
	logic [31:0] word_q;
	logic [4:0]  idx_q;

	logic          is_lf;
	logic          is_cr;
	logic          is_alpha;
	logic [7:0]    nib_full;
	logic [3:0]    nib;
	logic          char_store;
	logic          full;
	logic          store_en;
	logic [7:0]    store_byte;
	logic [5:0]    xpos;
	logic [XW-1:0] xpos_ext;
	logic          byte_ok;

	// character decode
	assign is_lf    = (char_beat.ascii_char == ihexld_pkg::CHAR_LF);
	assign is_cr    = (char_beat.ascii_char == ihexld_pkg::CHAR_CR);
	assign is_alpha = (char_beat.ascii_char >= ihexld_pkg::CHAR_UPPER_A) &&
	                  (char_beat.ascii_char <= ihexld_pkg::CHAR_UPPER_F);
	assign nib_full = is_alpha ? (char_beat.ascii_char - ihexld_pkg::HEX_ALPHA_OFS)
	                           : (char_beat.ascii_char - ihexld_pkg::HEX_DIGIT_OFS);
	assign nib      = nib_full[3:0];

	// byte store selection
	assign char_store = !is_lf && !is_cr && line_started_q && pend_q;
	assign full       = (count_q >= CW'(RECORD_BYTES));

	always_comb begin
		store_en   = 1'b0;
		store_byte = {hn_q, 4'h0};
		if (cmd.take_char && char_store) begin
			store_en   = !full;
			store_byte = {hn_q, nib};
		end else if (cmd.pad && pend_q) begin
			store_en = !full;
		end
	end

	// buffer position of the data byte being read, gated by line length and
	// by the record length field
	assign xpos     = 6'd4 + {1'b0, idx_q};
	assign xpos_ext = XW'(xpos);
	assign byte_ok  = (xpos_ext < XW'(count_q)) && ({3'b000, idx_q} < hdr_q[0]);

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[count_q[AW-1:0]] <= store_byte;
		end
		if (cmd.rd) begin
			rd_q <= byte_ok ? mem[xpos_ext[AW-1:0]] : 8'h00;
		end
	end

	// line and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			line_started_q <= 1'b0;
			pend_q         <= 1'b0;
			hn_q           <= 4'h0;
			sum_q          <= 8'h00;
			upper_q        <= 32'h0;
			erase_done_q   <= 1'b0;
			result_valid   <= 1'b0;
			for (int i = 0; i < ihexld_pkg::HDR_BYTES; i++) begin
				hdr_q[i] <= 8'h00;
			end
		end else begin
			// nibble pairing
			if (cmd.take_char && !is_lf && !is_cr) begin
				if (!line_started_q) begin
					line_started_q <= 1'b1;
				end else if (pend_q) begin
					pend_q <= 1'b0;
				end else begin
					hn_q   <= nib;
					pend_q <= 1'b1;
				end
			end
			if (cmd.pad) begin
				pend_q <= 1'b0;
			end
			// byte store with header capture
			if (store_en) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + store_byte;
				if (count_q < CW'(ihexld_pkg::HDR_BYTES)) begin
					hdr_q[count_q[2:0]] <= store_byte;
				end
			end
			// extended address records
			if (cmd.set_upper) begin
				if (hdr_q[3] == ihexld_pkg::REC_EXT_LIN) begin
					upper_q <= {hdr_q[4], hdr_q[5], 16'h0000};
				end else begin
					upper_q <= {12'h000, hdr_q[4], hdr_q[5], 4'h0};
				end
			end
			if (cmd.emit && (cmd.emit_kind == ihexld_pkg::KIND_ERASE)) begin
				erase_done_q <= 1'b1;
			end
			// line clear
			if (cmd.clear) begin
				count_q        <= '0;
				line_started_q <= 1'b0;
				pend_q         <= 1'b0;
				hn_q           <= 4'h0;
				sum_q          <= 8'h00;
				for (int i = 0; i < ihexld_pkg::HDR_BYTES; i++) begin
					hdr_q[i] <= 8'h00;
				end
			end
			// output valid
			if (cmd.emit) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// word assembly and output payload
	always_ff @(posedge clk) begin
		if (cmd.start_data) begin
			addr_q <= upper_q + {16'h0000, hdr_q[1], hdr_q[2]};
			word_q <= 32'h0;
			idx_q  <= 5'd0;
		end
		if (cmd.merge) begin
			word_q <= {rd_q, word_q[31:8]};
			idx_q  <= idx_q + 5'd1;
		end
		if (cmd.emit) begin
			result_beat.kind <= cmd.emit_kind;
			result_beat.last <= cmd.emit_last;
			if (cmd.emit_kind == ihexld_pkg::KIND_WRITE) begin
				result_beat.address   <= addr_q;
				result_beat.word_data <= word_q;
				addr_q                <= addr_q + 32'd4;
				word_q                <= 32'h0;
			end else if (cmd.emit_kind == ihexld_pkg::KIND_ERASE) begin
				result_beat.address   <= addr_q;
				result_beat.word_data <= 32'h0;
			end else begin
				result_beat.address   <= 32'h0;
				result_beat.word_data <= 32'h0;
			end
		end
	end

	// status to the controller
	always_comb begin
		sts.char_lf       = is_lf;
		sts.char_end      = char_beat.stream_end;
		sts.char_overflow = char_store && full;
		sts.pad_overflow  = pend_q && full;
		sts.count_zero    = (count_q == '0);
		sts.sum_nz        = (sum_q != 8'h00);
		sts.rec_type      = hdr_q[3];
		sts.len_zero      = (hdr_q[0] == 8'h00);
		sts.lane_last     = (idx_q[1:0] == 2'd3);
		sts.last_word     = ({3'b000, idx_q} >= hdr_q[0]) ||
		                    (idx_q >= 5'(ihexld_pkg::MAX_DATA_BYTES));
		sts.erase_done    = erase_done_q;
		sts.out_free      = !result_valid || !result_stall;
	end

endmodule

/* rtl/ihexld_ctrl.sv */
// controller of the intel hex record loader: sequences character intake,
// line close, record evaluation and result emission
// depends on ihexld_pkg
module ihexld_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  ihexld_pkg::sts_t sts,
	output ihexld_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PAD,
		S_EVAL,
		S_ERASE,
		S_RD,
		S_MRG,
		S_WORD,
		S_FAIL_LONG,
		S_FAIL_SUM,
		S_FAIL_EOF,
		S_STOP
	} state_t;

	state_t state_q;
	state_t state_d;

	// characters are taken while idle, and dropped once stopped
	assign char_stall = !((state_q == S_IDLE) || (state_q == S_STOP));

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					cmd.take_char = 1'b1;
					if (sts.char_overflow) begin
						state_d = S_FAIL_LONG;
					end else if (sts.char_lf || sts.char_end) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.pad = 1'b1;
				state_d = sts.pad_overflow ? S_FAIL_LONG : S_EVAL;
			end
			S_EVAL: begin
				if (sts.count_zero) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end else if (sts.sum_nz) begin
					state_d = S_FAIL_SUM;
				end else begin
					case (sts.rec_type)
						ihexld_pkg::REC_EXT_LIN, ihexld_pkg::REC_EXT_SEG: begin
							cmd.set_upper = 1'b1;
							cmd.clear     = 1'b1;
							state_d       = S_IDLE;
						end
						ihexld_pkg::REC_EOF: begin
							state_d = S_FAIL_EOF;
						end
						ihexld_pkg::REC_DATA: begin
							cmd.start_data = 1'b1;
							if (!sts.erase_done) begin
								state_d = S_ERASE;
							end else if (sts.len_zero) begin
								cmd.clear = 1'b1;
								state_d   = S_IDLE;
							end else begin
								state_d = S_RD;
							end
						end
						default: begin
							cmd.clear = 1'b1;
							state_d   = S_IDLE;
						end
					endcase
				end
			end
			S_ERASE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = ihexld_pkg::KIND_ERASE;
					cmd.emit_last = sts.len_zero;
					if (sts.len_zero) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MRG;
			end
			S_MRG: begin
				cmd.merge = 1'b1;
				state_d   = sts.lane_last ? S_WORD : S_RD;
			end
			S_WORD: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = ihexld_pkg::KIND_WRITE;
					cmd.emit_last = sts.last_word;
					if (sts.last_word) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_FAIL_LONG: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = ihexld_pkg::KIND_TOO_LONG;
					cmd.emit_last = 1'b1;
					state_d       = S_STOP;
				end
			end
			S_FAIL_SUM: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = ihexld_pkg::KIND_CSUM_ERR;
					cmd.emit_last = 1'b1;
					state_d       = S_STOP;
				end
			end
			S_FAIL_EOF: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = ihexld_pkg::KIND_EOF;
					cmd.emit_last = 1'b1;
					state_d       = S_STOP;
				end
			end
			S_STOP: begin
				state_d = S_STOP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/intel_hex_record_loader_unit.sv */
// intel hex record loader top level, joins ihexld_ctrl and ihexld_dp, uses ihexld_pkg
// throughput: a character that does not close a line is taken every cycle
// sequence: a closing character leads to pad and evaluate, then to any erase request and
// the data words (four byte reads, each a read and a merge, then the word beat); a result
// is registered on emit; a stalled one holds the sequence until the output register frees
// reset: line state, upper address and erase flag clear; once stopped every beat is dropped
module intel_hex_record_loader_unit #(
	parameter int RECORD_BYTES = ihexld_pkg::RECORD_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     char_valid,
	output logic                     char_stall,
	input  ihexld_pkg::char_beat_t   char_beat,
	output logic                     result_valid,
	input  logic                     result_stall,
	output ihexld_pkg::result_beat_t result_beat
);

	ihexld_pkg::cmd_t cmd;
	ihexld_pkg::sts_t sts;

	// sequencer
	ihexld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// record datapath
	ihexld_dp #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_beat    (char_beat),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

endmodule
